/* rtl/core/differential_drive_wheel_pid_assert.svh */
// Assertion macros shared by the wheel PID controller RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DIFFERENTIAL_DRIVE_WHEEL_PID_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_WHEEL_PID_ASSERT_SVH

// same-cycle implication
`define DDWP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ddwp assertion failed");

// next-cycle implication
`define DDWP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ddwp assertion failed");

`endif

/* rtl/core/ddwp_pkg.sv */
// Package for the wheel PID controller: widths, register codes, config and lane types.
// Used by ddwp_lane, ddwp_merge and differential_drive_wheel_pid; depends on nothing.
`timescale 1ns / 1ps

package ddwp_pkg;

   localparam int LANES         = 2;
   localparam int FRACTION_BITS = 16;

   localparam int GAIN_W   = 24;
   localparam int MID_W    = 15;
   localparam int PWM_W    = 16;
   localparam int CMD_W    = 32;
   localparam int STEP_W   = 32;
   localparam int MUL_A_W  = 33;
   localparam int MUL_B_W  = 25;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int RAW_W    = PROD_W;
   localparam int ERR_W    = 48;
   localparam int DIFF_W   = ERR_W + 1;
   localparam int OP_SPLIT = 24;
   localparam int ACC_W    = 76;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIN_WHEEL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANG_WHEEL  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SPEED = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_MID    = 3'd6;

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic [GAIN_W-1:0] deriv_gain;
      logic [GAIN_W-1:0] linear_to_wheel;
      logic [GAIN_W-1:0] angular_to_wheel;
      logic [GAIN_W-1:0] steps_to_speed;
      logic [MID_W-1:0]  pwm_mid;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      prop_gain:        24'd6554,
      integ_gain:       24'd196608,
      deriv_gain:       24'd32768,
      linear_to_wheel:  24'd2114065,
      angular_to_wheel: 24'd200838,
      steps_to_speed:   24'd52790,
      pwm_mid:          15'd500
   };

   typedef struct packed {
      logic                      start;
      logic                      stop;
      logic signed [CMD_W-1:0]   lin;
      logic signed [MUL_A_W-1:0] ang;
      logic [STEP_W-1:0]         steps;
   } lane_req_type;

   typedef struct packed {
      logic             busy;
      logic             valid;
      logic [PWM_W-1:0] pwm;
   } lane_rsp_type;

   typedef enum logic [3:0] {
      LS_IDLE,
      LS_LIN,
      LS_ANG,
      LS_SPD,
      LS_TGT,
      LS_ERR,
      LS_INT,
      LS_P_HI,
      LS_I_LO,
      LS_I_HI,
      LS_D_LO,
      LS_D_HI,
      LS_ACC,
      LS_OUT,
      LS_HOLD
   } lane_state_type;

   localparam logic signed [63:0] ERR_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] ERR_MIN = -ERR_MAX - 64'sd1;

   function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [63:0] x);
      logic signed [63:0] r;
      r = x;
      if (x > ERR_MAX) begin
         r = ERR_MAX;
      end else if (x < ERR_MIN) begin
         r = ERR_MIN;
      end
      return r[ERR_W-1:0];
   endfunction

endpackage

/* rtl/core/ddwp_lane.sv */
// One wheel lane: kinematics, speed measure and PID through one shared multiplier.
// Depends on ddwp_pkg.
`timescale 1ns / 1ps

module ddwp_lane #(
   parameter int FRACTION_BITS = ddwp_pkg::FRACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ddwp_pkg::cfg_type      cfg,
   input  ddwp_pkg::lane_req_type req,
   input  logic                   take,
   output ddwp_pkg::lane_rsp_type rsp
);

   localparam int SH = 2 * FRACTION_BITS;

   ddwp_pkg::lane_state_type state_ff, state_in;

   logic                                stop_ff;
   logic signed [ddwp_pkg::CMD_W-1:0]   lin_ff;
   logic signed [ddwp_pkg::MUL_A_W-1:0] ang_ff;
   logic [ddwp_pkg::STEP_W-1:0]         steps_ff;

   logic [ddwp_pkg::STEP_W-1:0]         last_steps_ff;
   logic signed [ddwp_pkg::ERR_W-1:0]   err_sum_ff;
   logic signed [ddwp_pkg::ERR_W-1:0]   last_err_ff;

   logic signed [ddwp_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ddwp_pkg::RAW_W-1:0]   raw_ff;
   logic signed [ddwp_pkg::RAW_W-1:0]   tgt_ff, tgt_in;
   logic signed [ddwp_pkg::PROD_W-1:0]  spd_ff;
   logic signed [ddwp_pkg::ERR_W-1:0]   e_ff;
   logic signed [ddwp_pkg::DIFF_W-1:0]  d_ff;
   logic signed [ddwp_pkg::ACC_W-1:0]   acc_ff;
   logic [ddwp_pkg::PWM_W-1:0]          pwm_ff, pwm_in;

   logic signed [ddwp_pkg::MUL_A_W-1:0] mul_a;
   logic signed [ddwp_pkg::MUL_B_W-1:0] mul_b;
   logic [ddwp_pkg::STEP_W-1:0]         delta;

   logic signed [ddwp_pkg::RAW_W-1:0]   raw_q;
   logic                                raw_up;
   logic signed [ddwp_pkg::RAW_W:0]     err_diff;
   logic signed [ddwp_pkg::ERR_W-1:0]   e_in;
   logic signed [ddwp_pkg::ERR_W-1:0]   sum_in;
   logic signed [ddwp_pkg::DIFF_W-1:0]  d_in;

   logic signed [ddwp_pkg::ACC_W-1:0]   out_q, out_t, mid_w, out_c;
   logic                                out_up;

   assign delta = steps_ff - last_steps_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ddwp_pkg::LS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff)
         ddwp_pkg::LS_IDLE: begin
            if (req.start) state_in = ddwp_pkg::LS_LIN;
         end
         ddwp_pkg::LS_LIN: begin
            state_in = ddwp_pkg::LS_ANG;
            mul_a    = {lin_ff[ddwp_pkg::CMD_W-1], lin_ff};
            mul_b    = {1'b0, cfg.linear_to_wheel};
         end
         ddwp_pkg::LS_ANG: begin
            state_in = ddwp_pkg::LS_SPD;
            mul_a    = ang_ff;
            mul_b    = {1'b0, cfg.angular_to_wheel};
         end
         ddwp_pkg::LS_SPD: begin
            state_in = ddwp_pkg::LS_TGT;
            mul_a    = {delta[ddwp_pkg::STEP_W-1], delta};
            mul_b    = {1'b0, cfg.steps_to_speed};
         end
         ddwp_pkg::LS_TGT: state_in = ddwp_pkg::LS_ERR;
         ddwp_pkg::LS_ERR: state_in = ddwp_pkg::LS_INT;
         ddwp_pkg::LS_INT: begin
            state_in = ddwp_pkg::LS_P_HI;
            mul_a    = {{(ddwp_pkg::MUL_A_W - ddwp_pkg::OP_SPLIT){1'b0}},
                        e_ff[ddwp_pkg::OP_SPLIT-1:0]};
            mul_b    = {1'b0, cfg.prop_gain};
         end
         ddwp_pkg::LS_P_HI: begin
            state_in = ddwp_pkg::LS_I_LO;
            mul_a    = {{(ddwp_pkg::MUL_A_W - ddwp_pkg::ERR_W + ddwp_pkg::OP_SPLIT)
                         {e_ff[ddwp_pkg::ERR_W-1]}},
                        e_ff[ddwp_pkg::ERR_W-1:ddwp_pkg::OP_SPLIT]};
            mul_b    = {1'b0, cfg.prop_gain};
         end
         ddwp_pkg::LS_I_LO: begin
            state_in = ddwp_pkg::LS_I_HI;
            mul_a    = {{(ddwp_pkg::MUL_A_W - ddwp_pkg::OP_SPLIT){1'b0}},
                        err_sum_ff[ddwp_pkg::OP_SPLIT-1:0]};
            mul_b    = {1'b0, cfg.integ_gain};
         end
         ddwp_pkg::LS_I_HI: begin
            state_in = ddwp_pkg::LS_D_LO;
            mul_a    = {{(ddwp_pkg::MUL_A_W - ddwp_pkg::ERR_W + ddwp_pkg::OP_SPLIT)
                         {err_sum_ff[ddwp_pkg::ERR_W-1]}},
                        err_sum_ff[ddwp_pkg::ERR_W-1:ddwp_pkg::OP_SPLIT]};
            mul_b    = {1'b0, cfg.integ_gain};
         end
         ddwp_pkg::LS_D_LO: begin
            state_in = ddwp_pkg::LS_D_HI;
            mul_a    = {{(ddwp_pkg::MUL_A_W - ddwp_pkg::OP_SPLIT){1'b0}},
                        d_ff[ddwp_pkg::OP_SPLIT-1:0]};
            mul_b    = {1'b0, cfg.deriv_gain};
         end
         ddwp_pkg::LS_D_HI: begin
            state_in = ddwp_pkg::LS_ACC;
            mul_a    = {{(ddwp_pkg::MUL_A_W - ddwp_pkg::DIFF_W + ddwp_pkg::OP_SPLIT)
                         {d_ff[ddwp_pkg::DIFF_W-1]}},
                        d_ff[ddwp_pkg::DIFF_W-1:ddwp_pkg::OP_SPLIT]};
            mul_b    = {1'b0, cfg.deriv_gain};
         end
         ddwp_pkg::LS_ACC:  state_in = ddwp_pkg::LS_OUT;
         ddwp_pkg::LS_OUT:  state_in = ddwp_pkg::LS_HOLD;
         ddwp_pkg::LS_HOLD: begin
            if (take) state_in = ddwp_pkg::LS_IDLE;
         end
         default: state_in = ddwp_pkg::LS_IDLE;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // target: trunc(raw / 2^2F) * 2^F
   assign raw_q  = raw_ff >>> SH;
   assign raw_up = raw_ff[ddwp_pkg::RAW_W-1] && (|raw_ff[SH-1:0]);
   assign tgt_in = (raw_q + {{(ddwp_pkg::RAW_W-1){1'b0}}, raw_up}) <<< FRACTION_BITS;

   assign err_diff = (ddwp_pkg::RAW_W + 1)'(tgt_ff) - (ddwp_pkg::RAW_W + 1)'(spd_ff);
   assign e_in     = ddwp_pkg::sat_err(64'(err_diff));
   assign sum_in   = ddwp_pkg::sat_err(64'(err_sum_ff) + 64'(e_ff));
   assign d_in     = ddwp_pkg::DIFF_W'(e_ff) - ddwp_pkg::DIFF_W'(last_err_ff);

   // output: trunc(acc / 2^2F), clamp to +/- mid, offset by mid
   assign out_q  = acc_ff >>> SH;
   assign out_up = acc_ff[ddwp_pkg::ACC_W-1] && (|acc_ff[SH-1:0]);
   assign out_t  = out_q + {{(ddwp_pkg::ACC_W-1){1'b0}}, out_up};
   assign mid_w  = ddwp_pkg::ACC_W'($signed({1'b0, cfg.pwm_mid}));

   always_comb begin
      out_c = out_t;
      if (out_t > mid_w) begin
         out_c = mid_w;
      end else if (out_t < -mid_w) begin
         out_c = -mid_w;
      end
      pwm_in = out_c[ddwp_pkg::PWM_W-1:0] + {1'b0, cfg.pwm_mid};
   end

   // per-wheel history
   always_ff @(posedge clock) begin
      if (reset) begin
         last_steps_ff <= '0;
         err_sum_ff    <= '0;
         last_err_ff   <= '0;
      end else begin
         if (state_ff == ddwp_pkg::LS_SPD) begin
            last_steps_ff <= steps_ff;
         end
         if (state_ff == ddwp_pkg::LS_INT) begin
            err_sum_ff  <= sum_in;
            last_err_ff <= e_ff;
         end
         if (state_ff == ddwp_pkg::LS_OUT && stop_ff) begin
            err_sum_ff  <= '0;
            last_err_ff <= '0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (state_ff)
         ddwp_pkg::LS_IDLE: begin
            if (req.start) begin
               stop_ff  <= req.stop;
               lin_ff   <= req.lin;
               ang_ff   <= req.ang;
               steps_ff <= req.steps;
            end
         end
         ddwp_pkg::LS_ANG: raw_ff <= -prod_ff;
         ddwp_pkg::LS_SPD: raw_ff <= raw_ff + prod_ff;
         ddwp_pkg::LS_TGT: begin
            tgt_ff <= tgt_in;
            spd_ff <= prod_ff;
         end
         ddwp_pkg::LS_ERR: e_ff <= e_in;
         ddwp_pkg::LS_INT: begin
            d_ff   <= d_in;
            acc_ff <= '0;
         end
         ddwp_pkg::LS_P_HI, ddwp_pkg::LS_I_HI, ddwp_pkg::LS_D_HI: begin
            acc_ff <= acc_ff + ddwp_pkg::ACC_W'(prod_ff);
         end
         ddwp_pkg::LS_I_LO, ddwp_pkg::LS_D_LO, ddwp_pkg::LS_ACC: begin
            acc_ff <= acc_ff + (ddwp_pkg::ACC_W'(prod_ff) <<< ddwp_pkg::OP_SPLIT);
         end
         ddwp_pkg::LS_OUT: pwm_ff <= pwm_in;
         default: ;
      endcase
   end

   assign rsp.busy  = (state_ff != ddwp_pkg::LS_IDLE);
   assign rsp.valid = (state_ff == ddwp_pkg::LS_HOLD);
   assign rsp.pwm   = pwm_ff;

endmodule

/* rtl/core/ddwp_merge.sv */
// Merge stage: joins the two lane results into one response and holds it for the sink.
// Depends on ddwp_pkg.
`timescale 1ns / 1ps

module ddwp_merge (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          accept,
   input  logic                                          stop,
   input  logic [ddwp_pkg::MID_W-1:0]                    pwm_mid,
   input  ddwp_pkg::lane_rsp_type [ddwp_pkg::LANES-1:0]  lane_rsp,
   output logic                                          take,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [2*ddwp_pkg::PWM_W-1:0]                  rsp_tdata,
   output logic [0:0]                                    rsp_tuser
);

   logic                        valid_ff, valid_in;
   logic                        stop_ff;
   logic                        enable_ff;
   logic [ddwp_pkg::PWM_W-1:0]  left_ff, right_ff;
   logic                        both;

   assign both = lane_rsp[0].valid && lane_rsp[1].valid;
   assign take = both && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // a stopped request drives both channels at mid
   always_ff @(posedge clock) begin
      if (accept) begin
         stop_ff <= stop;
      end
      if (take) begin
         left_ff   <= stop_ff ? {1'b0, pwm_mid} : lane_rsp[0].pwm;
         right_ff  <= stop_ff ? {1'b0, pwm_mid} : lane_rsp[1].pwm;
         enable_ff <= !stop_ff;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {right_ff, left_ff};
   assign rsp_tuser  = enable_ff;

endmodule

/* rtl/core/differential_drive_wheel_pid.sv */
// Two-wheel velocity PID controller for a differential-drive base: each request carries
// the linear and angular commands and both absolute encoder counts, and one response
// returns both PWM compare values and drive_enable. The two wheels run in separate
// lanes side by side, each with one 33x25 multiplier stepped through nine products
// (kinematics, speed, and the split P, I and D terms). A new request is taken only once both
// lanes have handed their previous results to the output register, which waits while the sink
// holds rsp_tready low. Configuration registers must be written through the csr port only
// while no request is in flight; the user must ensure this, the block does not enforce it.
// Depends on ddwp_pkg, ddwp_lane, ddwp_merge and differential_drive_wheel_pid_assert.svh.
`timescale 1ns / 1ps

`include "differential_drive_wheel_pid_assert.svh"

module differential_drive_wheel_pid #(
   parameter int FRACTION_BITS = ddwp_pkg::FRACTION_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: linear_cmd, angular_cmd, left_steps, right_steps
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [127:0]                      req_tdata,
   // response: left_pwm, right_pwm
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [2*ddwp_pkg::PWM_W-1:0]      rsp_tdata,
   // response flags: drive_enable
   output logic [0:0]                        rsp_tuser,
   input  logic                              csr_we,
   input  logic [ddwp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ddwp_pkg::GAIN_W-1:0]       csr_wdata
);

   ddwp_pkg::cfg_type                             cfg_ff;
   ddwp_pkg::lane_req_type [ddwp_pkg::LANES-1:0]  lane_req;
   ddwp_pkg::lane_rsp_type [ddwp_pkg::LANES-1:0]  lane_rsp;

   logic                               req_accept;
   logic                               lane_take;
   logic                               stop;
   logic signed [ddwp_pkg::CMD_W-1:0]  lin;
   logic signed [ddwp_pkg::CMD_W-1:0]  ang;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ddwp_pkg::CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ddwp_pkg::CSR_PROP_GAIN:  cfg_ff.prop_gain        <= csr_wdata;
            ddwp_pkg::CSR_INTEG_GAIN: cfg_ff.integ_gain       <= csr_wdata;
            ddwp_pkg::CSR_DERIV_GAIN: cfg_ff.deriv_gain       <= csr_wdata;
            ddwp_pkg::CSR_LIN_WHEEL:  cfg_ff.linear_to_wheel  <= csr_wdata;
            ddwp_pkg::CSR_ANG_WHEEL:  cfg_ff.angular_to_wheel <= csr_wdata;
            ddwp_pkg::CSR_STEP_SPEED: cfg_ff.steps_to_speed   <= csr_wdata;
            ddwp_pkg::CSR_PWM_MID:    cfg_ff.pwm_mid          <= csr_wdata[ddwp_pkg::MID_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !(lane_rsp[0].busy || lane_rsp[1].busy);
   assign req_accept = req_tvalid && req_tready;

   assign lin  = req_tdata[31:0];
   assign ang  = req_tdata[63:32];
   assign stop = (lin == '0) && (ang == '0);

   // right wheel takes the angular term with opposite sign
   always_comb begin
      lane_req[0].start = req_accept;
      lane_req[0].stop  = stop;
      lane_req[0].lin   = lin;
      lane_req[0].ang   = {ang[ddwp_pkg::CMD_W-1], ang};
      lane_req[0].steps = req_tdata[95:64];
      lane_req[1].start = req_accept;
      lane_req[1].stop  = stop;
      lane_req[1].lin   = lin;
      lane_req[1].ang   = -{ang[ddwp_pkg::CMD_W-1], ang};
      lane_req[1].steps = req_tdata[127:96];
   end

   for (genvar g = 0; g < ddwp_pkg::LANES; g++) begin : g_lane
      ddwp_lane #(
         .FRACTION_BITS(FRACTION_BITS)
      ) u_lane (
         .clock(clock),
         .reset(reset),
         .cfg  (cfg_ff),
         .req  (lane_req[g]),
         .take (lane_take),
         .rsp  (lane_rsp[g])
      );
   end

   ddwp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .stop      (stop),
      .pwm_mid   (cfg_ff.pwm_mid),
      .lane_rsp  (lane_rsp),
      .take      (lane_take),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   `DDWP_ASSERT_NXT(a_busy_after_accept, clock, reset, req_accept, !req_tready)
   `DDWP_ASSERT_IMP(a_lanes_lockstep, clock, reset, 1'b1, lane_rsp[0].valid == lane_rsp[1].valid)
   `DDWP_ASSERT_NXT(a_take_fills_output, clock, reset, lane_take, rsp_tvalid)
   `DDWP_ASSERT_IMP(a_no_accept_while_held, clock, reset, lane_rsp[0].valid, !req_tready)

endmodule

/* tb/wheel_pid_checker.sv */
// Response checker for differential_drive_wheel_pid: follows the csr, request and response ports,
// predicts both PWM compare values and drive_enable per request, and compares in order.
// Depends on ddwp_pkg for widths, register codes and reset values.
`timescale 1ns / 1ps

module wheel_pid_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [127:0]                   req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [2*ddwp_pkg::PWM_W-1:0]   rsp_tdata,
   input  logic [0:0]                     rsp_tuser,
   input  logic                           csr_we,
   input  logic [ddwp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ddwp_pkg::GAIN_W-1:0]    csr_wdata,
   output int                             mismatch_count,
   output int                             pending_count
);
   import ddwp_pkg::*;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [PWM_W-1:0] left_pwm;
      logic [PWM_W-1:0] right_pwm;
      logic             drive_enable;
   } wheel_cmd_type;

   localparam wide_type ERR_TOP = 128'sh7FFF_FFFF_FFFF;
   localparam wide_type ERR_BOT = -128'sh8000_0000_0000;

   cfg_type          shadow_cfg;
   logic [STEP_W-1:0] prev_steps [2];
   wide_type         integ_acc [2];
   wide_type         prev_err [2];
   wheel_cmd_type    drive_expect_q [$];
   int               fail_total = 0;
   int               rsp_seen = 0;

   function automatic wide_type clamp48(input wide_type x);
      if (x > ERR_TOP) return ERR_TOP;
      if (x < ERR_BOT) return ERR_BOT;
      return x;
   endfunction

   function automatic wide_type div_trunc(input wide_type x, input int k);
      wide_type m;
      if (x < 0) begin
         m = -x;
         return -(m >> k);
      end
      return x >> k;
   endfunction

   // advances the wheel state by one control tick
   function automatic wheel_cmd_type predict_drive(input logic [127:0] d);
      wheel_cmd_type     r;
      wide_type          lin, ang, kl, ka, ks, kp, ki, kd, mid;
      wide_type          raw, target, delta, e, dterm, o;
      wide_type          pwm [2];
      logic [STEP_W-1:0] steps;
      logic [STEP_W-1:0] step_diff;
      logic              stop;
      lin = $signed(d[31:0]);
      ang = $signed(d[63:32]);
      kp = shadow_cfg.prop_gain;
      ki = shadow_cfg.integ_gain;
      kd = shadow_cfg.deriv_gain;
      kl = shadow_cfg.linear_to_wheel;
      ka = shadow_cfg.angular_to_wheel;
      ks = shadow_cfg.steps_to_speed;
      mid = shadow_cfg.pwm_mid;
      stop = (d[31:0] == 0) && (d[63:32] == 0);
      for (int w = 0; w < 2; w++) begin
         steps = (w == 0) ? d[95:64] : d[127:96];
         raw = -(lin * kl);
         raw = (w == 0) ? raw + ang * ka : raw - ang * ka;
         target = div_trunc(raw, 2 * FRACTION_BITS) <<< FRACTION_BITS;
         step_diff = steps - prev_steps[w];
         delta = $signed(step_diff);
         e = clamp48(target - delta * ks);
         integ_acc[w] = clamp48(integ_acc[w] + e);
         dterm = e - prev_err[w];
         prev_err[w] = e;
         prev_steps[w] = steps;
         o = div_trunc(kp * e + ki * integ_acc[w] + kd * dterm, 2 * FRACTION_BITS);
         if (o > mid) o = mid;
         if (o < -mid) o = -mid;
         pwm[w] = mid + o;
         if (stop) begin
            integ_acc[w] = 0;
            prev_err[w] = 0;
            pwm[w] = mid;
         end
      end
      r.left_pwm = pwm[0][PWM_W-1:0];
      r.right_pwm = pwm[1][PWM_W-1:0];
      r.drive_enable = !stop;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      wheel_cmd_type got, want;
      if (reset) begin
         shadow_cfg = CFG_RESET;
         for (int w = 0; w < 2; w++) begin
            prev_steps[w] = '0;
            integ_acc[w] = 0;
            prev_err[w] = 0;
         end
         drive_expect_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.left_pwm = rsp_tdata[PWM_W-1:0];
            got.right_pwm = rsp_tdata[2*PWM_W-1:PWM_W];
            got.drive_enable = rsp_tuser[0];
            if (drive_expect_q.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("response %0d unexpected: left %0d right %0d enable %0b",
                           rsp_seen, got.left_pwm, got.right_pwm, got.drive_enable);
            end else begin
               want = drive_expect_q.pop_front();
               if (got.left_pwm !== want.left_pwm || got.right_pwm !== want.right_pwm ||
                   got.drive_enable !== want.drive_enable) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display("response %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                              rsp_seen, want.left_pwm, want.right_pwm, want.drive_enable,
                              got.left_pwm, got.right_pwm, got.drive_enable);
               end
            end
            rsp_seen++;
         end
         if (req_tvalid && req_tready)
            drive_expect_q.push_back(predict_drive(req_tdata));
         if (csr_we) begin
            case (csr_index)
               CSR_PROP_GAIN:  shadow_cfg.prop_gain = csr_wdata;
               CSR_INTEG_GAIN: shadow_cfg.integ_gain = csr_wdata;
               CSR_DERIV_GAIN: shadow_cfg.deriv_gain = csr_wdata;
               CSR_LIN_WHEEL:  shadow_cfg.linear_to_wheel = csr_wdata;
               CSR_ANG_WHEEL:  shadow_cfg.angular_to_wheel = csr_wdata;
               CSR_STEP_SPEED: shadow_cfg.steps_to_speed = csr_wdata;
               CSR_PWM_MID:    shadow_cfg.pwm_mid = csr_wdata[MID_W-1:0];
               default: ;
            endcase
         end
      end
      mismatch_count <= fail_total;
      pending_count <= drive_expect_q.size();
   end

endmodule

/* tb/tb.sv */
// Testbench top for differential_drive_wheel_pid: clock, reset, csr phases, request stimulus
// with random idling on both sides, and the verdict. Needs ddwp_pkg and wheel_pid_checker.
`timescale 1ns / 1ps

module tb;
   import ddwp_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 144;

   typedef enum int {
      MODE_TRACK,
      MODE_STOP,
      MODE_HALF,
      MODE_WILD,
      MODE_CORNER,
      MODE_WRAP
   } tick_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [127:0]           req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [2*PWM_W-1:0]     rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [GAIN_W-1:0]      csr_wdata;
   int                     mismatch_count;
   int                     pending_count;
   bit                     sink_hold = 1'b0;
   bit                     free_flow = 1'b0;
   logic [31:0]            last_left = '0;
   logic [31:0]            last_right = '0;

   differential_drive_wheel_pid uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   wheel_pid_checker pwm_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // tdata: linear_cmd, angular_cmd, left_steps, right_steps from the low bits up
   function automatic logic [127:0] tick_word(input logic [31:0] lin, ang, ls, rs);
      return {rs, ls, ang, lin};
   endfunction

   function automatic logic [GAIN_W-1:0] mid_word(input logic [MID_W-1:0] m);
      logic [GAIN_W-MID_W-1:0] junk;
      junk = (GAIN_W - MID_W)'($urandom_range(0, 511));
      return {junk, m};
   endfunction

   function automatic int small_signed(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic [31:0] corner_word();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'h0000_0001;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (free_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 20);
      return $urandom_range(30, 120);
   endfunction

   task automatic send_item(input logic [127:0] d);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      last_left = d[95:64];
      last_right = d[127:96];
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [GAIN_W-1:0] kp, ki, kd, kl, ka, ks, mid);
      csr_we <= 1'b1;
      csr_index <= CSR_PROP_GAIN;  csr_wdata <= kp;  @(posedge clock);
      csr_index <= CSR_INTEG_GAIN; csr_wdata <= ki;  @(posedge clock);
      csr_index <= CSR_DERIV_GAIN; csr_wdata <= kd;  @(posedge clock);
      csr_index <= CSR_LIN_WHEEL;  csr_wdata <= kl;  @(posedge clock);
      csr_index <= CSR_ANG_WHEEL;  csr_wdata <= ka;  @(posedge clock);
      csr_index <= CSR_STEP_SPEED; csr_wdata <= ks;  @(posedge clock);
      csr_index <= CSR_PWM_MID;    csr_wdata <= mid; @(posedge clock);
      // index past the register list must be ignored
      csr_index <= CSR_UNUSED;
      csr_wdata <= GAIN_W'($urandom_range(0, 24'hFF_FFFF));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // receiver
   initial begin : sink
      int r, len;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (sink_hold) begin
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
            sink_hold = 1'b0;
         end else if (free_flow) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            len = 0;
            if (r < 45) begin
               rsp_tready <= 1'b1;
               len = $urandom_range(1, 30);
            end else if (r < 75) begin
               rsp_tready <= 1'b0;
               len = $urandom_range(1, 3);
            end else if (r < 85) begin
               rsp_tready <= 1'b0;
               len = $urandom_range(4, 20);
            end else if (r < 89) begin
               rsp_tready <= 1'b0;
               len = $urandom_range(30, 100);
            end else if (r < 95) begin
               rsp_tready <= 1'b1;
               len = $urandom_range(100, 300);
            end else begin
               repeat ($urandom_range(10, 40)) begin
                  rsp_tready <= 1'($urandom_range(0, 1));
                  @(posedge clock);
               end
            end
            repeat (len) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      tick_mode_type mode;
      int            run_left, r, span;
      logic [31:0]   lin, ang, ls, rs;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = CSR_PROP_GAIN;
      csr_wdata = '0;
      mode = MODE_TRACK;
      run_left = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset gains, stop, command extremes, counter wrap
      send_item(tick_word(32'h0, 32'h0, 32'h0, 32'h0));
      send_item(tick_word(32'h1, 32'h0, 32'd5, -32'sd5));
      send_item(tick_word(32'h7FFF_FFFF, 32'h0, 32'd10, 32'd10));
      send_item(tick_word(32'h8000_0000, 32'h0, 32'd10, 32'd10));
      send_item(tick_word(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0));
      send_item(tick_word(32'h0, 32'h8000_0000, 32'h0, 32'h0));
      send_item(tick_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF));
      send_item(tick_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
      send_item(tick_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF));
      send_item(tick_word(32'h0, 32'h0, 32'h0, 32'h0));
      send_item(tick_word(32'h0001_0000, 32'h0000_8000, 32'd40, 32'd30));
      send_item(tick_word(32'h0001_0000, 32'h0000_8000, 32'd80, 32'd60));
      wait_drained();

      // saturating error and integral in both directions
      write_regs(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                 24'hFF_FFFF, mid_word(15'h7FFF));
      send_item(tick_word(32'h1, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF));
      send_item(tick_word(32'h1, 32'h0, 32'h0000_0000, 32'hFFFF_FFFE));
      send_item(tick_word(32'h1, 32'h0, 32'h8000_0000, 32'h7FFF_FFFD));
      send_item(tick_word(32'h1, 32'h0, 32'h0000_0000, 32'hFFFF_FFFC));
      send_item(tick_word(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFC));
      wait_drained();

      // zero mid
      write_regs(CFG_RESET.prop_gain, CFG_RESET.integ_gain, CFG_RESET.deriv_gain,
                 CFG_RESET.linear_to_wheel, CFG_RESET.angular_to_wheel,
                 CFG_RESET.steps_to_speed, mid_word(15'd0));
      send_item(tick_word(32'h0001_0000, 32'h0, 32'd100, 32'd100));
      send_item(tick_word(32'h0, 32'h0, 32'd100, 32'd100));
      send_item(tick_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0, 6: write_regs(CFG_RESET.prop_gain, CFG_RESET.integ_gain, CFG_RESET.deriv_gain,
                             CFG_RESET.linear_to_wheel, CFG_RESET.angular_to_wheel,
                             CFG_RESET.steps_to_speed, mid_word(CFG_RESET.pwm_mid));
            1: write_regs(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, mid_word(15'd1));
            2: write_regs(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                          24'hFF_FFFF, mid_word(15'h7FFF));
            4, 5: write_regs(GAIN_W'($urandom_range(0, 1 << 16)),
                             GAIN_W'($urandom_range(0, 1 << 19)),
                             GAIN_W'($urandom_range(0, 1 << 17)),
                             GAIN_W'($urandom_range(1 << 20, 1 << 22)),
                             GAIN_W'($urandom_range(1 << 16, 1 << 19)),
                             GAIN_W'($urandom_range(1 << 14, 1 << 17)),
                             mid_word(15'($urandom_range(100, 2000))));
            default: write_regs(GAIN_W'($urandom_range(0, 24'hFF_FFFF)),
                                GAIN_W'($urandom_range(0, 24'hFF_FFFF)),
                                GAIN_W'($urandom_range(0, 24'hFF_FFFF)),
                                GAIN_W'($urandom_range(0, 24'hFF_FFFF)),
                                GAIN_W'($urandom_range(0, 24'hFF_FFFF)),
                                GAIN_W'($urandom_range(0, 24'hFF_FFFF)),
                                mid_word(15'($urandom_range(1, 32767))));
         endcase
         free_flow = (phase == 6);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == 20) sink_hold = 1'b1;
            if (phase == 4 && n == PHASE_ITEMS / 2) wait_drained();
            if (run_left == 0) begin
               r = $urandom_range(0, 99);
               if (r < 50) mode = MODE_TRACK;
               else if (r < 60) mode = MODE_STOP;
               else if (r < 68) mode = MODE_HALF;
               else if (r < 83) mode = MODE_WILD;
               else if (r < 90) mode = MODE_CORNER;
               else mode = MODE_WRAP;
               run_left = $urandom_range(3, 25);
               if (mode == MODE_WRAP) begin
                  last_left = 32'h7FFF_FF00 + $urandom_range(0, 511);
                  last_right = 32'h8000_0100 - $urandom_range(0, 511);
               end
            end
            run_left--;
            span = ($urandom_range(0, 3) == 0) ? 3000 : 300;
            lin = small_signed(($urandom_range(0, 3) == 0) ? (1 << 12) : (1 << 17));
            ang = small_signed(($urandom_range(0, 3) == 0) ? (1 << 12) : (1 << 17));
            ls = last_left + small_signed(span);
            rs = last_right + small_signed(span);
            case (mode)
               MODE_STOP: begin
                  lin = '0;
                  ang = '0;
               end
               MODE_HALF: begin
                  if ($urandom_range(0, 1)) lin = '0;
                  else ang = '0;
               end
               MODE_WILD: begin
                  lin = $urandom();
                  ang = $urandom();
                  ls = $urandom();
                  rs = $urandom();
               end
               MODE_CORNER: begin
                  lin = corner_word();
                  ang = corner_word();
                  ls = corner_word();
                  rs = corner_word();
               end
               default: ;
            endcase
            send_item(tick_word(lin, ang, ls, rs));
         end
         wait_drained();
      end
      free_flow = 1'b0;

      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ddwp_pkg.sv
rtl/core/ddwp_lane.sv
rtl/core/ddwp_merge.sv
rtl/core/differential_drive_wheel_pid.sv
tb/wheel_pid_checker.sv
tb/tb.sv
